// ----- src/yel_pkg.sv -----
// Shared constants and types for the yEnc line encoder.
`timescale 1ns / 1ps

package yel_pkg;

    // Field and state widths
    localparam int BYTE_W = 8;
    localparam int LSIZE_W = 10;
    localparam int COL_W = 11;

    // Reset value of the line length register
    localparam logic [LSIZE_W-1:0] LINE_LEN_RST = 10'd128;

    // Encoding offsets
    localparam logic [BYTE_W-1:0] ENC_OFFSET = 8'd42;
    localparam logic [BYTE_W-1:0] ESC_OFFSET = 8'd64;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'd46;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'd61;

    // Characters produced by one item, and the column after it
    typedef struct packed {
        logic [3:0][BYTE_W-1:0] chars;
        logic [1:0]             last_idx;
        logic [COL_W-1:0]       column;
    } t_enc_run;

endpackage

// ----- src/yenc_line_encoder.sv -----
// Top level of the yEnc line encoder: input register, column state, line length register.
`timescale 1ns / 1ps

// Encodes one raw byte per item into yEnc characters, inserting CR LF once a
// line holds the configured number of characters and escaping by position on
// the line. Each result carries one character; last_of_run marks the final one
// of an item. An item yields 1 to 4 results, all on the single output port:
// plain bytes sustain one item per cycle while the output is not stalled, an
// escaped byte yields two results, a line break with an escaped byte four. The
// input register takes a new item while the previous run is still being played
// out. Write the line length only while the block is idle.
module yenc_line_encoder
    import yel_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_line_len_we,
    input  logic [LSIZE_W-1:0] i_line_len,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_in_byte,
    input  logic               i_end_of_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_last_of_run
);

    logic [LSIZE_W-1:0] r_line_len;
    logic [COL_W-1:0]   r_column;
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_end;
    logic               emit_free;
    logic               transfer;
    logic               accept;
    t_enc_run           run;

    // Handshake between input register and output stage
    always_comb begin
        transfer   = r_in_valid && emit_free;
        o_in_stall = r_in_valid && !emit_free;
        accept     = i_in_valid && !o_in_stall;
    end

    // Line length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= LINE_LEN_RST;
        end else if (i_line_len_we) begin
            r_line_len <= i_line_len;
        end
    end

    // Input register control and column state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_column   <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (transfer) begin
                r_in_valid <= 1'b0;
            end
            if (transfer) begin
                r_column <= run.column;
            end
        end
    end

    // Input item payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
            r_end     <= i_end_of_data;
        end
    end

    yel_encode u_encode (
        .i_in_byte     (r_in_byte),
        .i_end_of_data (r_end),
        .i_column      (r_column),
        .i_line_len    (r_line_len),
        .o_run         (run)
    );

    yel_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (transfer),
        .i_run         (run),
        .o_free        (emit_free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ----- src/yel_encode.sv -----
// Combinational yEnc encoding of one byte at the current column.
`timescale 1ns / 1ps

module yel_encode
    import yel_pkg::*;
(
    input  logic [BYTE_W-1:0]  i_in_byte,
    input  logic               i_end_of_data,
    input  logic [COL_W-1:0]   i_column,
    input  logic [LSIZE_W-1:0] i_line_len,
    output t_enc_run           o_run
);

    logic              at_start;
    logic              wrap;
    logic              middle;
    logic              start_rule;
    logic [BYTE_W-1:0] enc;
    logic [BYTE_W-1:0] enc_esc;
    logic              crit;
    logic              ws;
    logic              esc;
    logic [COL_W:0]    col_plus1;
    logic [COL_W-1:0]  col_base;
    logic [BYTE_W-1:0] first_char;

    // Position on the line selects the escape rule
    always_comb begin
        col_plus1  = {1'b0, i_column} + {{COL_W{1'b0}}, 1'b1};
        at_start   = (i_column == '0);
        wrap       = !at_start && (i_column >= {1'b0, i_line_len});
        middle     = !at_start && !wrap && (col_plus1 < {2'b00, i_line_len});
        start_rule = at_start || wrap;
    end

    // Escape decision; a trailing tab or space at end of data is escaped too
    always_comb begin
        enc     = i_in_byte + ENC_OFFSET;
        enc_esc = enc + ESC_OFFSET;
        crit    = (enc == CH_NUL) || (enc == CH_LF) || (enc == CH_CR) || (enc == CH_EQ);
        ws      = (enc == CH_TAB) || (enc == CH_SPACE);
        esc     = crit || (ws && (!middle || i_end_of_data))
                  || ((enc == CH_DOT) && start_rule);
        first_char = esc ? CH_EQ : enc;
    end

    // Assemble the run of characters and the next column
    always_comb begin
        o_run.chars = '0;
        if (wrap) begin
            o_run.chars[0] = CH_CR;
            o_run.chars[1] = CH_LF;
            o_run.chars[2] = first_char;
            o_run.chars[3] = enc_esc;
            o_run.last_idx = esc ? 2'd3 : 2'd2;
        end else begin
            o_run.chars[0] = first_char;
            o_run.chars[1] = enc_esc;
            o_run.last_idx = esc ? 2'd1 : 2'd0;
        end
        col_base     = start_rule ? '0 : i_column;
        o_run.column = col_base + (esc ? 11'd2 : 11'd1);
    end

endmodule

// ----- src/yel_emit.sv -----
// Output register that plays out a run of encoded characters, one per cycle while the output is not stalled.
`timescale 1ns / 1ps

module yel_emit
    import yel_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_enc_run          i_run,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last_of_run
);

    logic [3:0][BYTE_W-1:0] r_chars;
    logic [1:0]             r_last;
    logic [1:0]             r_idx;
    logic                   r_valid;
    logic                   at_last;
    logic                   take;

    always_comb begin
        at_last = (r_idx == r_last);
        take    = r_valid && !i_out_stall;
        o_free  = !r_valid || (take && at_last);
    end

    // Control: valid flag and read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    // Payload of the run
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chars <= i_run.chars;
            r_last  <= i_run.last_idx;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_chars[r_idx];
    assign o_last_of_run = at_last;

endmodule

// ----- test/tb_yenc_line_encoder.sv -----
// Self-checking testbench for the yEnc line encoder, with an in-bench encoder model.
`timescale 1ns / 1ps

module tb_yenc_line_encoder;
    import yel_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_GAP        = 8;

    // Raw bytes whose encoded form lands on a character the escape rules care about
    localparam logic [BYTE_W-1:0] RAW_NUL   = CH_NUL - ENC_OFFSET;
    localparam logic [BYTE_W-1:0] RAW_TAB   = CH_TAB - ENC_OFFSET;
    localparam logic [BYTE_W-1:0] RAW_LF    = CH_LF - ENC_OFFSET;
    localparam logic [BYTE_W-1:0] RAW_CR    = CH_CR - ENC_OFFSET;
    localparam logic [BYTE_W-1:0] RAW_SPACE = CH_SPACE - ENC_OFFSET;
    localparam logic [BYTE_W-1:0] RAW_DOT   = CH_DOT - ENC_OFFSET;
    localparam logic [BYTE_W-1:0] RAW_EQ    = CH_EQ - ENC_OFFSET;

    typedef enum logic [1:0] {POS_START, POS_MIDDLE, POS_LAST} t_line_pos;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } t_enc_char;

    // Encoder model: tracks column and line length, queues the characters each item yields
    class yenc_scoreboard;
        logic [LSIZE_W-1:0] line_len;
        logic [COL_W-1:0]   column;
        t_enc_char          enc_q[$];
        int                 errors;

        function new();
            line_len = LINE_LEN_RST;
            column   = '0;
            errors   = 0;
        endfunction

        function void set_line_len(logic [LSIZE_W-1:0] value);
            line_len = value;
        endfunction

        function int pending();
            return enc_q.size();
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // Escape decision for one encoded character at its place on the line
        function bit needs_escape(logic [BYTE_W-1:0] enc, t_line_pos pos);
            if (enc == CH_NUL || enc == CH_LF || enc == CH_CR || enc == CH_EQ)
                return 1'b1;
            if (pos != POS_MIDDLE && (enc == CH_TAB || enc == CH_SPACE))
                return 1'b1;
            if (pos == POS_START && enc == CH_DOT)
                return 1'b1;
            return 1'b0;
        endfunction

        function void note_item(logic [BYTE_W-1:0] raw, logic eod);
            logic [BYTE_W-1:0] chars [4];
            logic [BYTE_W-1:0] enc;
            logic [BYTE_W-1:0] tail;
            t_line_pos         pos;
            t_enc_char         item;
            int                n;
            int                width;
            int                k;
            n = 0;
            // Place on the line; a full line gets CR LF first
            if (column == '0) begin
                pos = POS_START;
            end else if (column >= line_len) begin
                chars[0] = CH_CR;
                chars[1] = CH_LF;
                n = 2;
                pos = POS_START;
            end else if (int'(column) + 1 < int'(line_len)) begin
                pos = POS_MIDDLE;
            end else begin
                pos = POS_LAST;
            end
            enc = raw + ENC_OFFSET;
            if (needs_escape(enc, pos)) begin
                chars[n]     = CH_EQ;
                chars[n + 1] = enc + ESC_OFFSET;
                width = 2;
            end else begin
                chars[n] = enc;
                width = 1;
            end
            n += width;
            if (pos == POS_START)
                column = COL_W'(width);
            else
                column = column + COL_W'(width);
            // End of data: a bare trailing tab or space gets escaped
            if (eod && n < 4) begin
                tail = chars[n - 1];
                if (tail == CH_TAB || tail == CH_SPACE) begin
                    chars[n - 1] = CH_EQ;
                    chars[n]     = tail + ESC_OFFSET;
                    n++;
                    column = column + 1'b1;
                end
            end
            for (k = 0; k < n; k++) begin
                item.ch   = chars[k];
                item.last = (k == n - 1);
                enc_q.push_back(item);
            end
        endfunction

        task check_char(logic [BYTE_W-1:0] ch, logic last);
            t_enc_char want;
            if (enc_q.size() == 0) begin
                report($sformatf("unexpected character 0x%02h last=%0b", ch, last));
                return;
            end
            want = enc_q.pop_front();
            if (ch !== want.ch)
                report($sformatf("out_byte 0x%02h, want 0x%02h", ch, want.ch));
            if (last !== want.last)
                report($sformatf("last_of_run %0b, want %0b (byte 0x%02h)", last,
                                 want.last, want.ch));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LSIZE_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [BYTE_W-1:0]  in_byte;
    logic               in_eod;
    logic               out_valid;
    logic               out_stall;
    logic [BYTE_W-1:0]  out_byte;
    logic               out_last;

    bit             send_idle;
    bit             recv_idle;
    int             hold_off_reqs = 0;
    int             quiet_cycles = 0;
    yenc_scoreboard sb;

    yenc_line_encoder u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_line_len_we  (cfg_we),
        .i_line_len     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_end_of_data  (in_eod),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (out_byte),
        .o_last_of_run  (out_last)
    );

    // 8 ns clock
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Seven of the sixteen cases pick bytes that encode onto escape-sensitive characters
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 15))
            0: return RAW_NUL;
            1: return RAW_LF;
            2: return RAW_CR;
            3: return RAW_EQ;
            4: return RAW_TAB;
            5: return RAW_SPACE;
            6: return RAW_DOT;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one item, returns at the edge where it is taken
    task automatic send_item(input logic [BYTE_W-1:0] raw, input logic eod);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= raw;
        in_eod   <= eod;
        do @(posedge clk); while (!(in_valid && !in_stall));
    endtask

    // Wait until every queued character has come out
    task automatic wait_drained();
        do @(negedge clk); while (sb.pending() != 0);
        @(posedge clk);
    endtask

    task automatic write_line_len(input logic [LSIZE_W-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_line_len(value);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_item(pick_byte(), $urandom_range(0, 5) == 0);
        in_valid <= 1'b0;
    endtask

    // Output side: random stall per character, plus one long hold-off on request
    initial begin : out_side
        int stall_n;
        int holds_done;
        holds_done = 0;
        out_stall <= 1'b1;
        wait (rst_n === 1'b1);
        forever begin
            stall_n = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_off_reqs != holds_done) begin
                stall_n += HOLD_CYCLES;
                holds_done = hold_off_reqs;
            end
            if (stall_n > 0) begin
                out_stall <= 1'b1;
                repeat (stall_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Handshake monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_char(out_byte, out_last);
            if (in_valid && !in_stall)
                sb.note_item(in_byte, in_eod);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int p;
        sb = new();
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_byte   <= '0;
        in_eod    <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, default line length: dot at line start vs. mid-line, always-escaped set,
        // tab and space mid-line, byte extremes, end of data on tab, space and escaped byte
        send_item(RAW_DOT, 1'b0);
        send_item(RAW_DOT, 1'b0);
        send_item(RAW_NUL, 1'b0);
        send_item(RAW_LF, 1'b0);
        send_item(RAW_CR, 1'b0);
        send_item(RAW_EQ, 1'b0);
        send_item(RAW_TAB, 1'b0);
        send_item(RAW_SPACE, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(RAW_TAB, 1'b1);
        send_item(RAW_SPACE, 1'b1);
        send_item(RAW_NUL, 1'b1);
        in_valid <= 1'b0;

        // Directed, short lines: shrink past the column, line break plus escape,
        // last-column tab and space, end of data after a line break
        write_line_len(LSIZE_W'(3));
        send_item(RAW_TAB, 1'b0);
        send_item(RAW_SPACE, 1'b0);
        send_item(RAW_DOT, 1'b0);
        send_item(RAW_TAB, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(RAW_SPACE, 1'b1);
        send_item(RAW_EQ, 1'b1);
        in_valid <= 1'b0;

        // Random phases, line length extremes first
        write_line_len(LSIZE_W'(1));
        run_random(14);
        write_line_len({LSIZE_W{1'b1}});
        run_random(14);

        // Output held off while input keeps coming, then a stretch with no idling
        write_line_len(LSIZE_W'(2));
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_off_reqs++;
        run_random(16);

        for (p = 0; p < 3; p++) begin
            if (p == 2)
                write_line_len(LSIZE_W'($urandom_range(1, 1023)));
            else
                write_line_len(LSIZE_W'($urandom_range(1, 12)));
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            run_random(16);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
